FILE: rtl/wuf_pkg.sv
package wuf_pkg;

  localparam int NumElements = 1024;
  localparam int IdxW        = $clog2(NumElements);
  localparam int SizeW       = 11;
  localparam int CountW      = 11;
  localparam int CfgAddrW    = 3;
  localparam int CfgDataW    = 32;

  localparam logic [SizeW-1:0]  SizeMax    = {SizeW{1'b1}};
  localparam logic [SizeW-1:0]  SizeOne    = SizeW'(1);
  localparam logic [CountW-1:0] CountReset = CountW'(NumElements);

  // Register index of element_count in the configuration map.
  localparam logic [0:0] RegElementCount = 1'b0;

  localparam logic OpQuery = 1'b0;
  localparam logic OpJoin  = 1'b1;

  localparam logic StatusOk    = 1'b0;
  localparam logic StatusRange = 1'b1;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_FIND_RD,
    S_FIND_PAR,
    S_FIND_GP,
    S_SIZE_P,
    S_SIZE_Q,
    S_JOIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    logic [IdxW-1:0] wdata;
  } par_req_t;

  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  addr;
    logic [SizeW-1:0] wdata;
  } sz_req_t;

endpackage

FILE: rtl/wuf_in_if.sv
interface wuf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [wuf_pkg::IdxW-1:0]  first_index;
  logic [wuf_pkg::IdxW-1:0]  second_index;

  modport source (output valid, operation, first_index, second_index, input ready);
  modport sink   (input valid, operation, first_index, second_index, output ready);
endinterface

FILE: rtl/wuf_out_if.sv
interface wuf_out_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic                      already_connected;
  logic [wuf_pkg::IdxW-1:0]  first_root;
  logic [wuf_pkg::IdxW-1:0]  second_root;

  modport source (output valid, status, already_connected, first_root, second_root,
                  input ready);
  modport sink   (input valid, status, already_connected, first_root, second_root,
                  output ready);
endinterface

FILE: rtl/weighted_union_find.sv
// Weighted union-find engine with path halving over 1024 elements.
// Each input beat on in_ch carries an operation (query or join) and two
// element indices p and q. Each beat produces exactly one result beat on
// out_ch with a status, an already-connected flag and the roots of p and q
// as found before any join. Indices at or above element_count give an
// error status and leave both tables untouched.
// The parent table and the size table are single-port memories with a
// registered read. A find runs halving steps until it reaches the root
// (read node, read parent, write grandparent back). A join of two
// distinct roots adds the size reads and the update. The result is
// registered when both finds, and for a join the update, are done and the
// output register is free; the next item can then be accepted, and one
// item is in work at a time.
// After reset the block writes every table entry back to its initial value
// (own parent, size one), and in_ch.ready stays low until that pass ends;
// element_count resets to 1024 and may be written through the cfg_ port
// at any time the engine is idle.
// The result sits in an output register, so the next item is accepted and
// processed while out_ch is stalled; only the following result waits.
module weighted_union_find (
  input  logic                          clk,
  input  logic                          rst_n,
  wuf_in_if.sink                        in_ch,
  wuf_out_if.source                     out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [wuf_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [wuf_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [wuf_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  logic [wuf_pkg::CountW-1:0] element_count;
  wuf_pkg::par_req_t          par_req;
  wuf_pkg::sz_req_t           sz_req;
  logic [wuf_pkg::IdxW-1:0]   par_rdata;
  logic [wuf_pkg::SizeW-1:0]  sz_rdata;

  // Configuration register block.
  wuf_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .element_count (element_count)
  );

  // Parent links: one entry per element, holding the index of its parent.
  wuf_ram #(
    .Depth (wuf_pkg::NumElements),
    .Width (wuf_pkg::IdxW)
  ) u_parent_ram (
    .clk   (clk),
    .we    (par_req.we),
    .addr  (par_req.addr),
    .wdata (par_req.wdata),
    .rdata (par_rdata)
  );

  // Tree sizes: only meaningful at roots, saturating at the field maximum.
  wuf_ram #(
    .Depth (wuf_pkg::NumElements),
    .Width (wuf_pkg::SizeW)
  ) u_size_ram (
    .clk   (clk),
    .we    (sz_req.we),
    .addr  (sz_req.addr),
    .wdata (sz_req.wdata),
    .rdata (sz_rdata)
  );

  // Sequencer: clearing pass, root walks with halving, join and result.
  wuf_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .element_count (element_count),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .par_req       (par_req),
    .par_rdata     (par_rdata),
    .sz_req        (sz_req),
    .sz_rdata      (sz_rdata)
  );

endmodule

FILE: rtl/wuf_ram.sv
module wuf_ram #(
  parameter int Depth = 1024,
  parameter int Width = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/wuf_cfg.sv
module wuf_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [wuf_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [wuf_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [wuf_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready,
  output logic [wuf_pkg::CountW-1:0]    element_count
);

  logic [wuf_pkg::CountW-1:0] count_r;
  logic [wuf_pkg::CountW-1:0] count_nxt;
  logic                       sel_count;

  // Registers sit on 4-byte boundaries, so bit 2 picks the register.
  assign sel_count = (cfg_paddr[2] == wuf_pkg::RegElementCount);

  always_comb begin
    count_nxt = count_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && sel_count) begin
      count_nxt = cfg_pwdata[wuf_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= wuf_pkg::CountReset;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign cfg_pready    = 1'b1;
  assign cfg_prdata    = sel_count ?
                         {{(wuf_pkg::CfgDataW-wuf_pkg::CountW){1'b0}}, count_r} :
                         '0;
  assign element_count = count_r;

endmodule

FILE: rtl/wuf_engine.sv
module wuf_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [wuf_pkg::CountW-1:0]    element_count,
  wuf_in_if.sink                        in_ch,
  wuf_out_if.source                     out_ch,
  output wuf_pkg::par_req_t             par_req,
  input  logic [wuf_pkg::IdxW-1:0]      par_rdata,
  output wuf_pkg::sz_req_t              sz_req,
  input  logic [wuf_pkg::SizeW-1:0]     sz_rdata
);

  wuf_pkg::state_t state_r, state_nxt;

  logic [wuf_pkg::IdxW-1:0]  init_cnt_r, init_cnt_nxt;
  logic                      op_r, op_nxt;
  logic [wuf_pkg::IdxW-1:0]  q_r, q_nxt;
  logic [wuf_pkg::IdxW-1:0]  node_r, node_nxt;
  logic                      which_r, which_nxt;
  logic [wuf_pkg::IdxW-1:0]  rp_r, rp_nxt;
  logic [wuf_pkg::IdxW-1:0]  rq_r, rq_nxt;
  logic [wuf_pkg::SizeW-1:0] sp_r, sp_nxt;
  logic                      status_r, status_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      o_status_r, o_status_nxt;
  logic                      o_conn_r, o_conn_nxt;
  logic [wuf_pkg::IdxW-1:0]  o_rp_r, o_rp_nxt;
  logic [wuf_pkg::IdxW-1:0]  o_rq_r, o_rq_nxt;

  logic                      accept;
  logic                      out_range;
  logic [wuf_pkg::SizeW:0]   size_sum;
  logic [wuf_pkg::SizeW-1:0] size_sat;

  assign accept    = in_ch.valid && in_ch.ready;
  assign out_range = ({1'b0, in_ch.first_index}  >= element_count) ||
                     ({1'b0, in_ch.second_index} >= element_count);
  assign size_sum  = {1'b0, sp_r} + {1'b0, sz_rdata};
  assign size_sat  = size_sum[wuf_pkg::SizeW] ? wuf_pkg::SizeMax :
                     size_sum[wuf_pkg::SizeW-1:0];

  always_comb begin
    state_nxt     = state_r;
    init_cnt_nxt  = init_cnt_r;
    op_nxt        = op_r;
    q_nxt         = q_r;
    node_nxt      = node_r;
    which_nxt     = which_r;
    rp_nxt        = rp_r;
    rq_nxt        = rq_r;
    sp_nxt        = sp_r;
    status_nxt    = status_r;
    o_status_nxt  = o_status_r;
    o_conn_nxt    = o_conn_r;
    o_rp_nxt      = o_rp_r;
    o_rq_nxt      = o_rq_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    par_req       = '{we: 1'b0, addr: node_r, wdata: '0};
    sz_req        = '{we: 1'b0, addr: rp_r, wdata: '0};
    in_ch.ready   = 1'b0;

    case (state_r)
      wuf_pkg::S_INIT: begin
        // One entry of each table per cycle: every node its own root, size one.
        par_req = '{we: 1'b1, addr: init_cnt_r, wdata: init_cnt_r};
        sz_req  = '{we: 1'b1, addr: init_cnt_r, wdata: wuf_pkg::SizeOne};
        init_cnt_nxt = init_cnt_r + 1'b1;
        if (init_cnt_r == wuf_pkg::IdxW'(wuf_pkg::NumElements - 1)) begin
          state_nxt = wuf_pkg::S_IDLE;
        end
      end
      wuf_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (accept) begin
          op_nxt    = in_ch.operation;
          q_nxt     = in_ch.second_index;
          node_nxt  = in_ch.first_index;
          which_nxt = 1'b0;
          if (out_range) begin
            status_nxt = wuf_pkg::StatusRange;
            rp_nxt     = '0;
            rq_nxt     = '0;
            state_nxt  = wuf_pkg::S_DONE;
          end else begin
            status_nxt = wuf_pkg::StatusOk;
            state_nxt  = wuf_pkg::S_FIND_RD;
          end
        end
      end
      wuf_pkg::S_FIND_RD: begin
        par_req.addr = node_r;
        state_nxt    = wuf_pkg::S_FIND_PAR;
      end
      wuf_pkg::S_FIND_PAR: begin
        if (par_rdata == node_r) begin
          if (!which_r) begin
            rp_nxt    = node_r;
            node_nxt  = q_r;
            which_nxt = 1'b1;
            state_nxt = wuf_pkg::S_FIND_RD;
          end else begin
            rq_nxt = node_r;
            if (op_r == wuf_pkg::OpJoin && rp_r != node_r) begin
              state_nxt = wuf_pkg::S_SIZE_P;
            end else begin
              state_nxt = wuf_pkg::S_DONE;
            end
          end
        end else begin
          // Fetch the grandparent; node_r keeps the address to relink.
          par_req.addr = par_rdata;
          state_nxt    = wuf_pkg::S_FIND_GP;
        end
      end
      wuf_pkg::S_FIND_GP: begin
        // Path halving: hang the node under its grandparent and move there.
        par_req   = '{we: 1'b1, addr: node_r, wdata: par_rdata};
        node_nxt  = par_rdata;
        state_nxt = wuf_pkg::S_FIND_RD;
      end
      wuf_pkg::S_SIZE_P: begin
        sz_req.addr = rp_r;
        state_nxt   = wuf_pkg::S_SIZE_Q;
      end
      wuf_pkg::S_SIZE_Q: begin
        sp_nxt      = sz_rdata;
        sz_req.addr = rq_r;
        state_nxt   = wuf_pkg::S_JOIN;
      end
      wuf_pkg::S_JOIN: begin
        if (sp_r < sz_rdata) begin
          par_req = '{we: 1'b1, addr: rp_r, wdata: rq_r};
          sz_req  = '{we: 1'b1, addr: rq_r, wdata: size_sat};
        end else begin
          par_req = '{we: 1'b1, addr: rq_r, wdata: rp_r};
          sz_req  = '{we: 1'b1, addr: rp_r, wdata: size_sat};
        end
        state_nxt = wuf_pkg::S_DONE;
      end
      wuf_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_conn_nxt    = (status_r == wuf_pkg::StatusOk) && (rp_r == rq_r);
          o_rp_nxt      = rp_r;
          o_rq_nxt      = rq_r;
          state_nxt     = wuf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wuf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wuf_pkg::S_INIT;
      init_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    q_r        <= q_nxt;
    node_r     <= node_nxt;
    which_r    <= which_nxt;
    rp_r       <= rp_nxt;
    rq_r       <= rq_nxt;
    sp_r       <= sp_nxt;
    status_r   <= status_nxt;
    o_status_r <= o_status_nxt;
    o_conn_r   <= o_conn_nxt;
    o_rp_r     <= o_rp_nxt;
    o_rq_r     <= o_rq_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = o_status_r;
  assign out_ch.already_connected = o_conn_r;
  assign out_ch.first_root        = o_rp_r;
  assign out_ch.second_root       = o_rq_r;

endmodule
